>>> design/cbhh_pkg.sv
// Shared types and constants for the character bigram hashing histogram.
package cbhh_pkg;

	localparam int CHAR_W      = 8;
	localparam int SEL_W       = 13;
	localparam int BIN_W       = 13;
	localparam int COUNT_W     = 16;
	localparam int SUM_W       = 9;   // sum of two bytes
	localparam int HASH_W      = 18;  // Cantor pair value before the modulo
	localparam int RECIP_W     = 20;  // reciprocal constant for the modulo
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CHAR_W-1:0] SPACE_CODE  = 8'd32;
	localparam logic [CHAR_W-1:0] TAB_CODE    = 8'd9;
	localparam logic [CHAR_W-1:0] LF_CODE     = 8'd10;
	localparam logic [CHAR_W-1:0] CR_CODE     = 8'd13;
	localparam logic [CHAR_W-1:0] N_CODE      = 8'd78;
	localparam logic [CHAR_W-1:0] UPPER_A     = 8'd65;
	localparam logic [CHAR_W-1:0] UPPER_Z     = 8'd90;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

	typedef enum logic [1:0] {
		MODE_PUSH    = 2'd0,
		MODE_FLUSH   = 2'd1,
		MODE_READ    = 2'd2,
		MODE_RESTART = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_PAIR,
		KIND_READ,
		KIND_SKIP,
		KIND_RESTART
	} kind_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [BIN_W-1:0]   bin;
		logic [COUNT_W-1:0] count;
		logic [BIN_W-1:0]   high_bin;
		logic               skipped;
	} result_t;

endpackage

>>> design/cbhh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbhh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 5000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/char_bigram_hash_histogram.sv
// Top level of the character bigram hashing histogram.
//
// Text bytes arrive as requests on the input channel, one per cycle at full
// rate while in_ready is high. A push request optionally lowers ASCII capitals
// (fold_case), drops tab, line feed, carriage return and (unless folded) capital
// N, and otherwise pairs the byte with the previous one (a space after reset,
// flush or restart). The pair is hashed with the Cantor pairing function modulo
// NUM_BINS and that bin's counter is bumped, saturating at 2^COUNT_BITS-1. A
// flush request counts the pair (previous, space); a read request returns a bin
// and zeroes it (a bin at or past NUM_BINS reads as zero); a restart resets the
// previous byte and the highest-bin tracker but keeps the counts. Every request
// yields exactly one result. The block takes one request per cycle while
// in_ready is high; each request passes through the quotient, remainder,
// correction-and-RAM-read and update stages before its result enters the
// queue. The counters live in one RAM with a registered read; the update stage
// writes back and forwards its write to the next request so back-to-back hits
// on the same bin count correctly. Results go to an 8-entry queue, and once
// clearing is done in_ready drops only when 8 requests are taken but not yet
// delivered. After reset the RAM is zeroed one entry per cycle, so in_ready
// stays low until every entry is cleared; fold_case can be written meanwhile.
module char_bigram_hash_histogram #(
	parameter int NUM_BINS   = 5000,
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_enable,
	input  logic                         cfg_write_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [cbhh_pkg::CHAR_W-1:0]  char_code,
	input  logic [cbhh_pkg::SEL_W-1:0]   bin_select,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cbhh_pkg::BIN_W-1:0]   bin,
	output logic [cbhh_pkg::COUNT_W-1:0] count,
	output logic [cbhh_pkg::BIN_W-1:0]   high_bin,
	output logic                         skipped
);

	import cbhh_pkg::*;

	localparam int IDX_W = $clog2(NUM_BINS);
	// floor(x / NUM_BINS) = (x * RECIP) >> SHIFT, exact for x < 2^HASH_W
	localparam int SHIFT = HASH_W + IDX_W;
	localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + NUM_BINS - 1) / NUM_BINS;
	localparam logic [RECIP_W-1:0]    RECIP     = RECIP_W'(RECIP_L);
	localparam logic [HASH_W-1:0]     NB_H      = HASH_W'(NUM_BINS);
	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(NUM_BINS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam int PEND_W = QPTR_W + 1;

	// ---------------- control state ----------------
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  clr_q;
	logic              clr_we;
	logic              fold_q;
	logic [CHAR_W-1:0] prev_q, prev_d;
	logic [IDX_W-1:0]  high_q, high_d;
	logic [PEND_W-1:0] pend_q;
	logic              in_acc, out_acc;

	assign in_ready = (state_q == ST_RUN) && (pend_q < PEND_W'(QUEUE_DEPTH));
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;

	// post-reset clearing pass over the counter RAM
	always_comb begin
		state_d = state_q;
		clr_we  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clr_we = 1'b1;
				if (clr_q == LAST_IDX) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				state_d = ST_RUN;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b1;
		end else if (cfg_write_enable) begin
			fold_q <= cfg_write_data;
		end
	end

	// ---------------- stage 0: decode and Cantor pair ----------------
	logic [CHAR_W-1:0]   char_f;
	logic                is_skip;
	logic [CHAR_W-1:0]   pair_b;
	kind_t               kind_in;
	logic [SUM_W-1:0]    pair_sum;
	logic [2*SUM_W:0]    pair_prod;
	logic [HASH_W-1:0]   hash_x;

	always_comb begin
		char_f = char_code;
		if (fold_q && char_code >= UPPER_A && char_code <= UPPER_Z) begin
			char_f = char_code + CASE_OFFSET;
		end
		is_skip = char_f inside {TAB_CODE, LF_CODE, CR_CODE, N_CODE};
		pair_b  = SPACE_CODE;
		kind_in = KIND_SKIP;
		prev_d  = prev_q;
		case (mode_t'(mode))
			MODE_PUSH: begin
				if (!is_skip) begin
					kind_in = KIND_PAIR;
					pair_b  = char_f;
					prev_d  = char_f;
				end
			end
			MODE_FLUSH: begin
				kind_in = KIND_PAIR;
				prev_d  = SPACE_CODE;
			end
			MODE_READ: begin
				kind_in = KIND_READ;
			end
			MODE_RESTART: begin
				kind_in = KIND_RESTART;
				prev_d  = SPACE_CODE;
			end
			default: begin
				kind_in = KIND_SKIP;
			end
		endcase
		// s + 1 stays below 2^SUM_W since s <= 510
		pair_sum  = SUM_W'(prev_q) + SUM_W'(pair_b);
		pair_prod = (2*SUM_W+1)'(pair_sum) * (2*SUM_W+1)'(pair_sum + 1'b1);
		hash_x    = HASH_W'(pair_prod >> 1) + HASH_W'(pair_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= SPACE_CODE;
		end else if (in_acc) begin
			prev_q <= prev_d;
		end
	end

	// ---------------- pipeline registers ----------------
	logic                v_s1, v_s2, v_s3, v_s4;
	kind_t               kind_s1, kind_s2, kind_s3, kind_s4;
	logic [SEL_W-1:0]    sel_s1, sel_s2, sel_s3, sel_s4;
	logic                sel_ok_s1, sel_ok_s2, sel_ok_s3, sel_ok_s4;
	logic [HASH_W-1:0]   x_s1, x_s2;
	logic [HASH_W-1:0]   q_s2;
	logic [HASH_W-1:0]   r_s3;
	logic [IDX_W-1:0]    addr_s4;

	// stage 1: quotient by reciprocal
	logic [HASH_W+RECIP_W-1:0] recip_prod;
	logic [HASH_W-1:0]         quot;
	assign recip_prod = (HASH_W+RECIP_W)'(x_s1) * (HASH_W+RECIP_W)'(RECIP);
	assign quot       = HASH_W'(recip_prod >> SHIFT);

	// stage 2: remainder
	logic [2*HASH_W-1:0] back_prod;
	logic [HASH_W-1:0]   rem;
	assign back_prod = (2*HASH_W)'(q_s2) * (2*HASH_W)'(NB_H);
	assign rem       = x_s2 - back_prod[HASH_W-1:0];

	// stage 3: final correction and RAM read address
	logic [HASH_W-1:0] rem_fix;
	logic [IDX_W-1:0]  rd_addr;
	always_comb begin
		rem_fix = (r_s3 >= NB_H) ? r_s3 - NB_H : r_s3;
		rd_addr = (kind_s3 == KIND_READ) ? IDX_W'(sel_s3) : IDX_W'(rem_fix);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1   <= kind_in;
		sel_s1    <= bin_select;
		sel_ok_s1 <= (32'(bin_select) < 32'(NUM_BINS));
		x_s1      <= hash_x;

		kind_s2   <= kind_s1;
		sel_s2    <= sel_s1;
		sel_ok_s2 <= sel_ok_s1;
		x_s2      <= x_s1;
		q_s2      <= quot;

		kind_s3   <= kind_s2;
		sel_s3    <= sel_s2;
		sel_ok_s3 <= sel_ok_s2;
		r_s3      <= rem;

		kind_s4   <= kind_s3;
		sel_s4    <= sel_s3;
		sel_ok_s4 <= sel_ok_s3;
		addr_s4   <= rd_addr;
	end

	// ---------------- counter RAM ----------------
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;

	cbhh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_BINS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// ---------------- stage 4: update, write back, forward ----------------
	logic                  fwd_vld_q;
	logic [IDX_W-1:0]      fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;
	logic [COUNT_BITS-1:0] cur_val, new_val;
	logic                  upd_we;
	result_t               res;

	always_comb begin
		// the previous cycle's write missed this request's RAM read
		cur_val = (fwd_vld_q && fwd_addr_q == addr_s4) ? fwd_data_q : ram_rdata;
		new_val = cur_val;
		upd_we  = 1'b0;
		high_d  = high_q;
		res     = '0;
		case (kind_s4)
			KIND_PAIR: begin
				new_val = (cur_val == COUNT_MAX) ? cur_val : cur_val + 1'b1;
				upd_we  = v_s4;
				if (addr_s4 > high_q) begin
					high_d = addr_s4;
				end
				res.bin      = BIN_W'(addr_s4);
				res.count    = COUNT_W'(new_val);
				res.high_bin = BIN_W'(high_d);
			end
			KIND_READ: begin
				new_val  = '0;
				upd_we   = v_s4 && sel_ok_s4;
				res.bin  = sel_s4;
				if (sel_ok_s4) begin
					res.count = COUNT_W'(cur_val);
				end
				res.high_bin = BIN_W'(high_q);
			end
			KIND_SKIP: begin
				res.high_bin = BIN_W'(high_q);
				res.skipped  = 1'b1;
			end
			KIND_RESTART: begin
				high_d      = '0;
				res.skipped = 1'b1;
			end
			default: begin
				res.skipped = 1'b1;
			end
		endcase
	end

	assign ram_we    = clr_we || upd_we;
	assign ram_waddr = clr_we ? clr_q : addr_s4;
	assign ram_wdata = clr_we ? '0 : new_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
			high_q    <= '0;
		end else begin
			fwd_vld_q <= upd_we;
			if (v_s4) begin
				high_q <= high_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s4;
		fwd_data_q <= new_val;
	end

	// ---------------- result queue ----------------
	result_t           queue_q [QUEUE_DEPTH];
	logic [PEND_W-1:0] wr_ptr_q, rd_ptr_q;
	result_t           head;

	always_ff @(posedge clk) begin
		if (v_s4) begin
			queue_q[wr_ptr_q[QPTR_W-1:0]] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			pend_q   <= '0;
		end else begin
			if (v_s4) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({in_acc, out_acc})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	assign head      = queue_q[rd_ptr_q[QPTR_W-1:0]];
	assign out_valid = (wr_ptr_q != rd_ptr_q);
	assign bin       = head.bin;
	assign count     = head.count;
	assign high_bin  = head.high_bin;
	assign skipped   = head.skipped;

endmodule

>>> design/cbhh_checker.sv
// Port-level checks for the character bigram hashing histogram, with bind.
module cbhh_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [cbhh_pkg::BIN_W-1:0]   bin,
	input logic [cbhh_pkg::COUNT_W-1:0] count,
	input logic [cbhh_pkg::BIN_W-1:0]   high_bin,
	input logic                         skipped
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin) && $stable(count)
			&& $stable(high_bin) && $stable(skipped))
		else $error("result changed while stalled");

	// skipped bytes and restarts carry no bin and no count
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skipped |-> bin == '0 && count == '0)
		else $error("skipped result has bin or count");

	// RAM clearing pass follows reset: no requests taken, nothing pending
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !in_ready && !out_valid)
		else $error("block active right after reset");

endmodule

bind char_bigram_hash_histogram cbhh_checker u_cbhh_checker (.*);

>>> tb/sv/bigram_histogram_checker.sv
// Checker for the bigram histogram: predicts every result and compares it with the block.
module bigram_histogram_checker #(
	parameter int NUM_BINS   = 5000,
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_enable,
	input  logic                         cfg_write_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [cbhh_pkg::CHAR_W-1:0]  char_code,
	input  logic [cbhh_pkg::SEL_W-1:0]   bin_select,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [cbhh_pkg::BIN_W-1:0]   bin,
	input  logic [cbhh_pkg::COUNT_W-1:0] count,
	input  logic [cbhh_pkg::BIN_W-1:0]   high_bin,
	input  logic                         skipped,
	output int                           mismatches,
	output int                           outstanding,
	output logic [cbhh_pkg::BIN_W-1:0]   recent_bin
);
	import cbhh_pkg::*;

	logic [COUNT_BITS-1:0] bin_counts [NUM_BINS];
	logic [CHAR_W-1:0]     last_char;
	logic [BIN_W-1:0]      top_bin;
	logic                  fold;
	result_t               pending_results [$];
	int                    mismatch_total;

	// Cantor pairing b + (a+b)(a+b+1)/2, folded into the bin range
	function automatic logic [BIN_W-1:0] pair_bin(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
		int s;
		s = int'(a) + int'(b);
		return BIN_W'((int'(b) + s * (s + 1) / 2) % NUM_BINS);
	endfunction

	function automatic result_t bump_pair(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
		logic [BIN_W-1:0] idx;
		result_t r;
		idx = pair_bin(a, b);
		if (bin_counts[idx] != '1)
			bin_counts[idx] = bin_counts[idx] + 1'b1;
		if (idx > top_bin)
			top_bin = idx;
		r.bin      = idx;
		r.count    = COUNT_W'(bin_counts[idx]);
		r.high_bin = top_bin;
		r.skipped  = 1'b0;
		return r;
	endfunction

	function automatic result_t histogram_step(mode_t m, logic [CHAR_W-1:0] c,
			logic [SEL_W-1:0] sel);
		logic [CHAR_W-1:0] ch;
		result_t r;
		r  = '0;
		ch = c;
		case (m)
		MODE_PUSH: begin
			if (fold && ch >= UPPER_A && ch <= UPPER_Z)
				ch = ch + CASE_OFFSET;
			if (ch == TAB_CODE || ch == LF_CODE || ch == CR_CODE || ch == N_CODE) begin
				r.high_bin = top_bin;
				r.skipped  = 1'b1;
			end else begin
				r = bump_pair(last_char, ch);
				last_char = ch;
			end
		end
		MODE_FLUSH: begin
			r = bump_pair(last_char, SPACE_CODE);
			last_char = SPACE_CODE;
		end
		MODE_READ: begin
			r.bin = BIN_W'(sel);
			if (sel < NUM_BINS) begin
				r.count = COUNT_W'(bin_counts[sel]);
				bin_counts[sel] = '0;
			end
			r.high_bin = top_bin;
		end
		default: begin
			// restart keeps the counts
			last_char = SPACE_CODE;
			top_bin   = '0;
			r.skipped = 1'b1;
		end
		endcase
		return r;
	endfunction

	function automatic void note_mismatch(logic orphan, result_t want, result_t got);
		mismatch_total++;
		if (mismatch_total <= 10) begin
			if (orphan)
				$display("unexpected result: bin=%0d count=%0d high_bin=%0d skipped=%0d",
					got.bin, got.count, got.high_bin, got.skipped);
			else
				$display("result error: expected bin=%0d count=%0d high_bin=%0d skipped=%0d, got bin=%0d count=%0d high_bin=%0d skipped=%0d",
					want.bin, want.count, want.high_bin, want.skipped,
					got.bin, got.count, got.high_bin, got.skipped);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++)
				bin_counts[i] = '0;
			last_char = SPACE_CODE;
			top_bin   = '0;
			fold      = 1'b1;
			pending_results.delete();
			mismatch_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
			recent_bin  <= '0;
		end else begin
			if (out_valid && out_ready) begin
				got = {bin, count, high_bin, skipped};
				if (pending_results.size() == 0) begin
					note_mismatch(1'b1, '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want)
						note_mismatch(1'b0, want, got);
				end
			end
			if (cfg_write_enable)
				fold = cfg_write_data;
			if (in_valid && in_ready) begin
				want = histogram_step(mode_t'(mode), char_code, bin_select);
				pending_results.push_back(want);
				if (!want.skipped && mode_t'(mode) != MODE_READ)
					recent_bin <= want.bin;
			end
			mismatches  <= mismatch_total;
			outstanding <= pending_results.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the bigram histogram: stimulus, flow control and verdict.
module tb;
	import cbhh_pkg::*;

	localparam int NUM_BINS    = 5000;
	localparam int COUNT_BITS  = 16;
	// longest run of cycles with no request or result moving; it has to cover
	// the clearing pass after reset
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD   = 400;
	localparam int SAT_RUN     = 200;    // a long run of hits on one bin
	localparam int PHASE_ITEMS = 280;
	localparam int DRAIN_WAIT  = 12;     // extra wait after settle before the verdict
	// Cantor pair of (space, space): 32 + 64*65/2 = 2112, below NUM_BINS
	localparam logic [SEL_W-1:0] SPACE_PAIR_BIN = 13'd2112;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write_enable = 1'b0;
	logic               cfg_write_data = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	mode_t              req_mode = MODE_PUSH;
	logic [CHAR_W-1:0]  req_char = '0;
	logic [SEL_W-1:0]   req_sel = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [BIN_W-1:0]   res_bin;
	logic [COUNT_W-1:0] res_count;
	logic [BIN_W-1:0]   res_high_bin;
	logic               res_skipped;

	int                 mismatches;
	int                 outstanding;
	logic [BIN_W-1:0]   recent_bin;

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int holds_requested    = 0;   // bumped by stimulus only
	int holds_served       = 0;   // owned by the receiver process
	int hold_left          = 0;
	int quiet_cycles       = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	char_bigram_hash_histogram #(
		.NUM_BINS  (NUM_BINS),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_enable(cfg_write_enable),
		.cfg_write_data  (cfg_write_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (req_mode),
		.char_code       (req_char),
		.bin_select      (req_sel),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bin             (res_bin),
		.count           (res_count),
		.high_bin        (res_high_bin),
		.skipped         (res_skipped)
	);

	bigram_histogram_checker #(
		.NUM_BINS  (NUM_BINS),
		.COUNT_BITS(COUNT_BITS)
	) histogram_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_enable(cfg_write_enable),
		.cfg_write_data  (cfg_write_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (req_mode),
		.char_code       (req_char),
		.bin_select      (req_sel),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bin             (res_bin),
		.count           (res_count),
		.high_bin        (res_high_bin),
		.skipped         (res_skipped),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.recent_bin      (recent_bin)
	);

	// Result side: random back-pressure, plus a long hold-off on request so the
	// 8-deep result queue fills and the block has to drop in_ready.
	always @(posedge clk) begin
		if (holds_served != holds_requested) begin
			holds_served = holds_requested;
			hold_left    = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Watchdog: nothing moving on either channel for too long means a hang.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// One request: optional idle cycles first, then hold valid until taken.
	task automatic send(input mode_t m, input logic [CHAR_W-1:0] c, input logic [SEL_W-1:0] s);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_mode <= m;
		req_char <= c;
		req_sel  <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every result owed has been delivered. The
	// extra edge lets the checker count the request taken on the last one.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_fold_case(input logic v);
		settle();
		cfg_write_enable <= 1'b1;
		cfg_write_data   <= v;
		@(posedge clk);
		cfg_write_enable <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] any_char();
		return CHAR_W'($urandom_range(255));
	endfunction

	function automatic logic [SEL_W-1:0] any_sel();
		return SEL_W'($urandom_range(2**SEL_W - 1));
	endfunction

	// Text from a narrow alphabet so pairs repeat and counts climb; mixed case,
	// capital N, whitespace to skip, and now and then an arbitrary byte.
	function automatic logic [CHAR_W-1:0] text_char();
		int r = $urandom_range(99);
		if (r < 52)
			return CHAR_W'(UPPER_A + CASE_OFFSET + $urandom_range(5));
		if (r < 66)
			return SPACE_CODE;
		if (r < 78)
			return CHAR_W'(UPPER_A + $urandom_range(5));
		if (r < 84)
			return N_CODE;
		if (r < 87)
			return N_CODE + CASE_OFFSET;
		if (r < 90)
			return TAB_CODE;
		if (r < 92)
			return LF_CODE;
		if (r < 94)
			return CR_CODE;
		return any_char();
	endfunction

	// Reads mostly target the bin touched last so they return real counts.
	function automatic logic [SEL_W-1:0] read_target();
		int r = $urandom_range(99);
		if (r < 60)
			return recent_bin;
		if (r < 85)
			return SEL_W'($urandom_range(NUM_BINS - 1));
		return any_sel();
	endfunction

	task automatic random_request();
		int r = $urandom_range(99);
		if (r < 78)
			send(MODE_PUSH, text_char(), any_sel());
		else if (r < 86)
			send(MODE_FLUSH, any_char(), any_sel());
		else if (r < 97)
			send(MODE_READ, any_char(), read_target());
		else
			send(MODE_RESTART, any_char(), any_sel());
	endtask

	task automatic random_phase(input logic fold, input int idle_pct, input int stall_pct,
			input logic long_hold);
		set_fold_case(fold);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		if (long_hold)
			holds_requested++;
		repeat (PHASE_ITEMS)
			random_request();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// fold_case may be written while the counters are still being cleared
		set_fold_case(1'b1);

		// Directed: folding, skips, byte extremes, back-to-back hits on one
		// bin, flush, reads in and out of range, restart.
		send(MODE_PUSH, "a", '0);
		send(MODE_PUSH, "a", '0);
		send(MODE_PUSH, "A", '0);               // folds to 'a', same bin again
		send(MODE_PUSH, N_CODE, '0);            // folded, so counted
		send(MODE_PUSH, TAB_CODE, '0);
		send(MODE_PUSH, LF_CODE, '0);
		send(MODE_PUSH, CR_CODE, '0);
		send(MODE_PUSH, 8'h00, '0);
		send(MODE_PUSH, 8'hFF, '1);
		send(MODE_PUSH, UPPER_Z, '0);
		send(MODE_FLUSH, 8'hFF, '1);
		send(MODE_FLUSH, 8'h00, '0);            // pair of two spaces
		send(MODE_READ, '0, SPACE_PAIR_BIN);
		send(MODE_READ, '0, '0);
		send(MODE_READ, '0, SEL_W'(NUM_BINS - 1));
		send(MODE_READ, '0, SEL_W'(NUM_BINS));  // first bin past the end
		send(MODE_READ, '0, '1);
		send(MODE_RESTART, '1, '1);
		send(MODE_PUSH, UPPER_A - 1'b1, '0);    // just outside the capitals
		send(MODE_PUSH, UPPER_Z + 1'b1, '0);
		set_fold_case(1'b0);
		send(MODE_PUSH, N_CODE, '0);            // skipped now
		send(MODE_PUSH, UPPER_A, '0);           // kept as a capital
		send(MODE_PUSH, N_CODE + CASE_OFFSET, '0);
		send(MODE_FLUSH, '0, '0);
		send(MODE_RESTART, '0, '0);

		// Back-to-back flushes all land on the space-pair bin
		set_fold_case(1'b1);
		repeat (SAT_RUN)
			send(MODE_FLUSH, '0, '0);
		send(MODE_READ, '0, SPACE_PAIR_BIN);
		send(MODE_READ, '0, SPACE_PAIR_BIN);

		random_phase(1'b0, 0, 0, 1'b0);
		random_phase(1'b1, 56, 0, 1'b0);
		random_phase(1'b0, 0, 56, 1'b1);        // long hold while requests keep coming
		random_phase(1'b1, 21, 21, 1'b0);

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
design/cbhh_pkg.sv
design/cbhh_ram.sv
design/char_bigram_hash_histogram.sv
design/cbhh_checker.sv
tb/sv/bigram_histogram_checker.sv
tb/sv/tb.sv
